### rtl/ps2md_pkg.sv
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

    // header byte bit positions
    localparam int unsigned SYNC_BIT   = 3;
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;
    localparam int unsigned X_OVF_BIT  = 6;
    localparam int unsigned Y_OVF_BIT  = 7;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // packet slots
    localparam logic [1:0] SLOT_HDR   = 2'd0;
    localparam logic [1:0] SLOT_X     = 2'd1;
    localparam logic [1:0] SLOT_Y     = 2'd2;
    localparam logic [1:0] LAST_SLOT3 = 2'd2;
    localparam logic [1:0] LAST_SLOT4 = 2'd3;

    // one good packet, as handed from the front end to the back end
    typedef struct packed {
        logic [8:0] dx;
        logic       y_sign;
        logic [7:0] y_byte;
        logic [3:0] wheel;
        logic [2:0] buttons;
    } t_motion;

endpackage

### rtl/ps2_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// PS/2 mouse packet decoder with optional four-byte wheel packets.
// ----------------------------------------------------------------------------
// Input channel: one mouse byte per transfer (i_in_valid / o_in_stall).
// While waiting for a header, bytes without the sync bit are dropped.
// Output channel: one result per good packet (o_out_valid / i_out_stall);
// packets with an X or Y overflow bit give no result.
// Config channel: i_cfg_valid / o_cfg_ready writes wheel_mode; ready is
// always high and a write restarts packet assembly.
// Throughput: one byte per cycle while the queue is not full. The byte that
// ends a packet is written as a record into the queue at its transfer edge;
// the record moves on into the output register when that register is free.
// When the receiver stalls, the output register holds and the queue
// (QUEUE_DEPTH records) fills; o_in_stall rises only once it is full.
// Reset (synchronous, active low) clears the packet position, wheel mode,
// the last-button state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder #(
    parameter int unsigned QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_wheel_mode,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [8:0]   o_delta_x,
    output logic signed [9:0]   o_delta_y_screen,
    output logic signed [3:0]   o_wheel_delta,
    output logic        [2:0]   o_button_state,
    output logic        [2:0]   o_button_changed
);
    import ps2md_pkg::*;

    logic    in_accept;
    logic    push, pop, q_full, q_valid;
    t_motion push_data, q_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    ps2md_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_wheel_mode (i_cfg_wheel_mode),
        .o_push           (push),
        .o_push_data      (push_data)
    );

    ps2md_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    ps2md_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_data           (q_data),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_delta_x        (o_delta_x),
        .o_delta_y_screen (o_delta_y_screen),
        .o_wheel_delta    (o_wheel_delta),
        .o_button_state   (o_button_state),
        .o_button_changed (o_button_changed)
    );

endmodule

### rtl/ps2md_front.sv
// ----------------------------------------------------------------------------
// ps2md_front
// Byte assembler: syncs on header bytes, collects packet bytes, drops
// overflow packets and emits one motion record per good packet.
// ----------------------------------------------------------------------------
module ps2md_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wheel_mode,
    output logic                o_push,
    output ps2md_pkg::t_motion  o_push_data
);
    import ps2md_pkg::*;

    logic       r_wheel_mode, n_wheel_mode;
    logic [1:0] r_byte_pos, n_byte_pos;
    logic [7:0] r_hdr, r_xb, r_yb;
    logic [1:0] last_slot;
    logic       ends_packet;
    logic       drop_byte;

    assign last_slot   = r_wheel_mode ? LAST_SLOT4 : LAST_SLOT3;
    assign drop_byte   = (r_byte_pos == SLOT_HDR) && !i_rx_byte[SYNC_BIT];
    assign ends_packet = !drop_byte && (r_byte_pos >= last_slot);

    always_comb begin
        n_wheel_mode = r_wheel_mode;
        n_byte_pos   = r_byte_pos;
        if (i_accept && !drop_byte) begin
            n_byte_pos = ends_packet ? SLOT_HDR : r_byte_pos + 2'd1;
        end
        // mode change restarts assembly
        if (i_cfg_we) begin
            n_wheel_mode = i_cfg_wheel_mode;
            n_byte_pos   = SLOT_HDR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= 1'b0;
            r_byte_pos   <= SLOT_HDR;
        end else begin
            r_wheel_mode <= n_wheel_mode;
            r_byte_pos   <= n_byte_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !drop_byte && !ends_packet) begin
            case (r_byte_pos)
                SLOT_HDR: r_hdr <= i_rx_byte;
                SLOT_X:   r_xb  <= i_rx_byte;
                SLOT_Y:   r_yb  <= i_rx_byte;
                default:  r_yb  <= i_rx_byte;
            endcase
        end
    end

    always_comb begin
        o_push_data.dx      = {r_hdr[X_SIGN_BIT], r_xb};
        o_push_data.y_sign  = r_hdr[Y_SIGN_BIT];
        o_push_data.y_byte  = r_wheel_mode ? r_yb : i_rx_byte;
        o_push_data.wheel   = r_wheel_mode ? i_rx_byte[3:0] : 4'd0;
        o_push_data.buttons = r_hdr[2:0];
    end

    assign o_push = i_accept && ends_packet && !r_hdr[X_OVF_BIT] && !r_hdr[Y_OVF_BIT];

endmodule

### rtl/ps2md_queue.sv
// ----------------------------------------------------------------------------
// ps2md_queue
// Small FIFO of motion records between the assembler and the output stage.
// ----------------------------------------------------------------------------
module ps2md_queue #(
    parameter int unsigned DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ps2md_pkg::t_motion  i_push_data,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output ps2md_pkg::t_motion  o_data
);
    import ps2md_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_motion          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### rtl/ps2md_back.sv
// ----------------------------------------------------------------------------
// ps2md_back
// Output stage: negates Y to screen sense, tracks button changes and holds
// the result register toward the receiver.
// ----------------------------------------------------------------------------
module ps2md_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ps2md_pkg::t_motion  i_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [8:0]   o_delta_x,
    output logic signed [9:0]   o_delta_y_screen,
    output logic signed [3:0]   o_wheel_delta,
    output logic        [2:0]   o_button_state,
    output logic        [2:0]   o_button_changed
);
    import ps2md_pkg::*;

    logic       r_out_valid, n_out_valid;
    logic [2:0] r_last_buttons;
    logic [8:0] r_dx;
    logic [9:0] r_dy;
    logic [3:0] r_wheel;
    logic [2:0] r_btn, r_changed;
    logic [9:0] y10;

    assign o_pop = i_valid && (!r_out_valid || !i_out_stall);
    assign y10   = {{2{i_data.y_sign}}, i_data.y_byte};

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_last_buttons <= 3'd0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_last_buttons <= i_data.buttons;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dx      <= i_data.dx;
            r_dy      <= 10'd0 - y10;
            r_wheel   <= i_data.wheel;
            r_btn     <= i_data.buttons;
            r_changed <= i_data.buttons ^ r_last_buttons;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_delta_x        = r_dx;
    assign o_delta_y_screen = r_dy;
    assign o_wheel_delta    = r_wheel;
    assign o_button_state   = r_btn;
    assign o_button_changed = r_changed;

endmodule

### rtl/ps2md_checker.sv
// ----------------------------------------------------------------------------
// ps2md_checker
// Port-level checks for the PS/2 mouse packet decoder, bound to the top.
// ----------------------------------------------------------------------------
module ps2md_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready,
    input  logic                i_cfg_wheel_mode,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic [7:0]          i_rx_byte,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic signed [8:0]   o_delta_x,
    input  logic signed [9:0]   o_delta_y_screen,
    input  logic signed [3:0]   o_wheel_delta,
    input  logic        [2:0]   o_button_state,
    input  logic        [2:0]   o_button_changed
);
    logic [2:0] r_prev_btn;

    // buttons of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn <= 3'd0;
        end else if (o_out_valid && !i_out_stall) begin
            r_prev_btn <= o_button_state;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_delta_x)
            && $stable(o_delta_y_screen) && $stable(o_button_changed))
        else $error("stalled result changed");

    a_changed_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_button_changed == (o_button_state ^ r_prev_btn))
        else $error("button change mask inconsistent with delivered buttons");

    // negated 9-bit motion never reaches -256 or below
    a_dy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_delta_y_screen[9:8] != 2'b10
            && o_delta_y_screen != 10'h300)
        else $error("screen Y motion out of range");

endmodule

bind ps2_mouse_packet_decoder ps2md_checker u_ps2md_checker (.*);

### tb/ps2_mouse_packet_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_test
// Self-checking bench for the PS/2 mouse packet decoder. Mouse bytes are sent
// in three- and four-byte modes, first a short directed set, then random
// packets with noise and cut-off packets, while both channels idle at random
// outside one no-idle run. A scoreboard decodes the same byte stream and
// checks every report in order.
module ps2_mouse_packet_decoder_test;
    import ps2md_pkg::*;

    typedef struct packed {
        logic signed [8:0] dx;
        logic signed [9:0] dy;
        logic signed [3:0] wheel;
        logic        [2:0] buttons;
        logic        [2:0] changed;
    } mouse_report_t;

    class mouse_scoreboard;
        bit                 wheel_on;
        logic [7:0]         slots [3];
        logic [1:0]         slot_pos  = SLOT_HDR;
        logic [2:0]         last_btns = 3'd0;
        mouse_report_t      reports_due [$];
        int unsigned        errors;

        function void set_wheel_mode(input logic m);
            wheel_on = m;
            // a mode change throws away any partial packet
            slot_pos = SLOT_HDR;
        endfunction

        function void note_byte(input logic [7:0] b);
            logic [1:0]    end_slot;
            logic [7:0]    hdr;
            logic [7:0]    y_byte;
            logic [9:0]    y_ext;
            mouse_report_t r;
            end_slot = wheel_on ? LAST_SLOT4 : LAST_SLOT3;
            if (slot_pos == SLOT_HDR && !b[SYNC_BIT])
                return;
            if (slot_pos < end_slot) begin
                slots[slot_pos] = b;
                slot_pos = slot_pos + 2'd1;
                return;
            end
            slot_pos = SLOT_HDR;
            hdr = slots[SLOT_HDR];
            if (hdr[X_OVF_BIT] || hdr[Y_OVF_BIT])
                return;
            y_byte    = wheel_on ? slots[SLOT_Y] : b;
            y_ext     = {{2{hdr[Y_SIGN_BIT]}}, y_byte};
            r.dx      = {hdr[X_SIGN_BIT], slots[SLOT_X]};
            r.dy      = ~y_ext + 10'd1;    // screen y grows downward
            r.wheel   = wheel_on ? b[3:0] : 4'd0;
            r.buttons = hdr[2:0];
            r.changed = hdr[2:0] ^ last_btns;
            last_btns = hdr[2:0];
            reports_due.push_back(r);
        endfunction

        function void flag(input string what);
            if (errors < 10)
                $display("%0t: %s", $time, what);
            errors++;
        endfunction

        function void check_report(input mouse_report_t got);
            mouse_report_t want;
            if (reports_due.size() == 0) begin
                flag($sformatf("report with none due: dx %0d dy %0d wheel %0d btn %b chg %b",
                               got.dx, got.dy, got.wheel, got.buttons, got.changed));
                return;
            end
            want = reports_due.pop_front();
            if (got.dx !== want.dx || got.dy !== want.dy || got.wheel !== want.wheel ||
                    got.buttons !== want.buttons || got.changed !== want.changed)
                flag($sformatf({"report mismatch: exp dx %0d dy %0d wheel %0d btn %b chg %b",
                                " / got dx %0d dy %0d wheel %0d btn %b chg %b"},
                               want.dx, want.dy, want.wheel, want.buttons, want.changed,
                               got.dx, got.dy, got.wheel, got.buttons, got.changed));
        endfunction
    endclass

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_cfg_valid      = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_wheel_mode = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_rx_byte        = 8'd0;
    logic              o_out_valid;
    logic              i_out_stall      = 1'b0;
    logic signed [8:0] o_delta_x;
    logic signed [9:0] o_delta_y_screen;
    logic signed [3:0] o_wheel_delta;
    logic [2:0]        o_button_state;
    logic [2:0]        o_button_changed;

    bit                no_idle = 1'b0;
    mouse_scoreboard   sb;

    ps2_mouse_packet_decoder u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_wheel_mode (i_cfg_wheel_mode),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_delta_x        (o_delta_x),
        .o_delta_y_screen (o_delta_y_screen),
        .o_wheel_delta    (o_wheel_delta),
        .o_button_state   (o_button_state),
        .o_button_changed (o_button_changed)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit idle_roll();
        return !no_idle && ($urandom_range(99) < 17);
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= idle_roll();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_report({o_delta_x, o_delta_y_screen, o_wheel_delta,
                             o_button_state, o_button_changed});
    end

    // valid is left high after a transfer; the next call lowers it only for a gap
    task automatic push_byte(input logic [7:0] b);
        if (idle_roll()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (idle_roll());
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b);
    endtask

    task automatic drain(input int unsigned extra);
        while (sb.reports_due.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_wheel_mode(input logic m);
        i_in_valid <= 1'b0;
        drain(8);
        i_cfg_valid      <= 1'b1;
        i_cfg_wheel_mode <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_wheel_mode(m);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly whole packets; some stray bytes and some packets cut short
    task automatic send_random(input int unsigned budget);
        int unsigned sent;
        int unsigned roll;
        int unsigned len;
        logic [7:0]  hdr;
        sent = 0;
        while (sent < budget) begin
            roll = $urandom_range(99);
            len  = sb.wheel_on ? 4 : 3;
            if (roll < 10) begin
                push_byte(8'($urandom));
                sent++;
            end else begin
                hdr = 8'($urandom);
                hdr[SYNC_BIT] = 1'b1;
                if ($urandom_range(9) != 0)
                    hdr[Y_OVF_BIT:X_OVF_BIT] = 2'b00;
                if (roll < 18)
                    len = $urandom_range(len - 1, 1);
                push_byte(hdr);
                for (int k = 1; k < len; k++)
                    push_byte(8'($urandom));
                sent += len;
            end
        end
    endtask

    initial begin
        logic [7:0] seq [$];
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // three-byte mode: headers without sync, zero motion, all signs and
        // buttons, most negative x and y, an overflowed packet
        seq = '{8'h00, 8'hF7,
                8'h08, 8'h00, 8'h00,
                8'h3F, 8'hFF, 8'hFF,
                8'h39, 8'h00, 8'h00,
                8'hCF, 8'h12, 8'h34};
        foreach (seq[i]) push_byte(seq[i]);

        // wheel mode: wheel extremes, then a packet cut off by a mode change
        write_wheel_mode(1'b1);
        seq = '{8'h0A, 8'h7F, 8'hFF, 8'h07,
                8'h0C, 8'h01, 8'h02, 8'hF8,
                8'h08, 8'h55};
        foreach (seq[i]) push_byte(seq[i]);
        write_wheel_mode(1'b0);

        send_random(300);
        write_wheel_mode(1'b1);
        send_random(300);
        write_wheel_mode(1'b0);
        no_idle = 1'b1;
        send_random(150);
        no_idle = 1'b0;
        write_wheel_mode(1'b1);
        send_random(150);

        i_in_valid <= 1'b0;
        drain(20);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/ps2md_pkg.sv
rtl/ps2md_front.sv
rtl/ps2md_queue.sv
rtl/ps2md_back.sv
rtl/ps2_mouse_packet_decoder.sv
rtl/ps2md_checker.sv
tb/ps2_mouse_packet_decoder_test.sv
